// ===== rtl/gtm_pkg.sv =====
// ----------------------------------------------------------------------------
// gtm_pkg
// types, constants and the multiply-accumulate step table of the tone detector
// ----------------------------------------------------------------------------
package gtm_pkg;

   localparam int SAMPLE_BITS = 12;
   localparam int COEFF_BITS  = 16;
   localparam int LEN_BITS    = 9;
   localparam int Q_BITS      = 48;
   localparam int CHUNK_BITS  = 24;
   localparam int ACC_BITS    = 112;
   localparam int FRAC_BITS   = 14;
   localparam int MAG_BITS    = 32;
   localparam int RAD_BITS    = 2 * MAG_BITS;
   localparam int STEP_BITS   = 4;
   localparam int SHIFT_BITS  = 7;
   localparam int ROOT_STEPS  = MAG_BITS;
   localparam int ITER_BITS   = $clog2(ROOT_STEPS);
   localparam int CSR_BITS    = 2;

   localparam logic [LEN_BITS-1:0]    MAX_BLOCK    = 9'd256;
   localparam logic [COEFF_BITS-1:0]  COEFF_RESET  = 16'd0;
   localparam logic [SAMPLE_BITS-1:0] CENTER_RESET = 12'd512;
   localparam logic [LEN_BITS-1:0]    LEN_RESET    = 9'd128;

   localparam logic [Q_BITS-1:0] Q_MAX = {1'b0, {(Q_BITS-1){1'b1}}};
   localparam logic [Q_BITS-1:0] Q_MIN = {1'b1, {(Q_BITS-1){1'b0}}};

   localparam logic [STEP_BITS-1:0] STEP_MAC_FIRST = 4'd0;
   localparam logic [STEP_BITS-1:0] STEP_MAC_LAST  = 4'd1;
   localparam logic [STEP_BITS-1:0] STEP_POW_FIRST = 4'd2;
   localparam logic [STEP_BITS-1:0] STEP_POW_LAST  = 4'd15;

   typedef enum logic [CSR_BITS-1:0] {
      CSR_COEFF  = 2'd0,
      CSR_CENTER = 2'd1,
      CSR_LENGTH = 2'd2
   } csr_index_type;

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_MAC    = 9'b000000010,
      ST_UPDATE = 9'b000000100,
      ST_ABS    = 9'b000001000,
      ST_POWER  = 9'b000010000,
      ST_PREP   = 9'b000100000,
      ST_ROOT   = 9'b001000000,
      ST_DONE   = 9'b010000000,
      ST_SPARE  = 9'b100000000
   } state_type;

   typedef enum logic [2:0] {
      OPND_COEFF,
      OPND_A1_LO,
      OPND_A1_HI,
      OPND_A2_LO,
      OPND_A2_HI,
      OPND_T_0,
      OPND_T_1,
      OPND_T_2
   } opnd_type;

   typedef enum logic [1:0] {
      ACC_ADD,
      ACC_SIGNED,
      ACC_SIGNED_INV
   } accop_type;

   typedef struct packed {
      opnd_type                a_sel;
      opnd_type                b_sel;
      logic [SHIFT_BITS-1:0]   shift;
      accop_type               op;
      logic                    restart;
   } step_type;

   function automatic step_type make_step(input opnd_type a, input opnd_type b,
                                          input logic [SHIFT_BITS-1:0] sh,
                                          input accop_type op, input logic rs);
      step_type s;
      s.a_sel   = a;
      s.b_sel   = b;
      s.shift   = sh;
      s.op      = op;
      s.restart = rs;
      return s;
   endfunction

   // steps 0-1: coeff*q1 per sample; 2-15: power of the finished block
   function automatic step_type step_ctl(input logic [STEP_BITS-1:0] idx);
      step_type s;
      s = make_step(OPND_COEFF, OPND_A1_LO, 7'd0, ACC_ADD, 1'b0);
      case (idx)
         4'd0:  s = make_step(OPND_COEFF, OPND_A1_LO, 7'd0,  ACC_SIGNED, 1'b0);
         4'd1:  s = make_step(OPND_COEFF, OPND_A1_HI, 7'd24, ACC_SIGNED, 1'b0);
         4'd2:  s = make_step(OPND_COEFF, OPND_A1_LO, 7'd0,  ACC_ADD, 1'b0);
         4'd3:  s = make_step(OPND_COEFF, OPND_A1_HI, 7'd24, ACC_ADD, 1'b0);
         4'd4:  s = make_step(OPND_A1_LO, OPND_A1_LO, 7'd14, ACC_ADD, 1'b1);
         4'd5:  s = make_step(OPND_A1_LO, OPND_A1_HI, 7'd39, ACC_ADD, 1'b0);
         4'd6:  s = make_step(OPND_A1_HI, OPND_A1_HI, 7'd62, ACC_ADD, 1'b0);
         4'd7:  s = make_step(OPND_A2_LO, OPND_A2_LO, 7'd14, ACC_ADD, 1'b0);
         4'd8:  s = make_step(OPND_A2_LO, OPND_A2_HI, 7'd39, ACC_ADD, 1'b0);
         4'd9:  s = make_step(OPND_A2_HI, OPND_A2_HI, 7'd62, ACC_ADD, 1'b0);
         4'd10: s = make_step(OPND_T_0, OPND_A2_LO, 7'd0,  ACC_SIGNED_INV, 1'b0);
         4'd11: s = make_step(OPND_T_0, OPND_A2_HI, 7'd24, ACC_SIGNED_INV, 1'b0);
         4'd12: s = make_step(OPND_T_1, OPND_A2_LO, 7'd24, ACC_SIGNED_INV, 1'b0);
         4'd13: s = make_step(OPND_T_1, OPND_A2_HI, 7'd48, ACC_SIGNED_INV, 1'b0);
         4'd14: s = make_step(OPND_T_2, OPND_A2_LO, 7'd48, ACC_SIGNED_INV, 1'b0);
         4'd15: s = make_step(OPND_T_2, OPND_A2_HI, 7'd72, ACC_SIGNED_INV, 1'b0);
         default: s = make_step(OPND_COEFF, OPND_A1_LO, 7'd0, ACC_ADD, 1'b0);
      endcase
      return s;
   endfunction

   function automatic logic [Q_BITS-1:0] q_abs(input logic [Q_BITS-1:0] v);
      return v[Q_BITS-1] ? (~v + 1'b1) : v;
   endfunction

endpackage

// ===== rtl/goertzel_tone_magnitude.sv =====
// ----------------------------------------------------------------------------
// goertzel_tone_magnitude
// single-bin tone detector: one adc sample per transfer, one magnitude per block
// ----------------------------------------------------------------------------
// req_* carries one raw adc sample per transfer; req_stall is high while an
// item is in work. csr_* writes coeff (index 0), center (index 1) and
// block_length (index 2) and is always ready; write it only while idle.
// rsp_* carries magnitude and overflowed once per block of samples.
// A sample is handled in turn: accept, two passes through the shared 24x24
// multiply-accumulate unit for coeff*q1, then the history update.
// The last sample of a block then goes on to the operand magnitudes, 14
// multiply-accumulate passes for the block power, the range check, 32 steps
// of the radix-2 square root loop and the load of the output register.
// The result waits in the output register, so the next sample is
// taken while a stalled result is still pending; a new result is held back
// only while the previous one has not been transferred.
// Synchronous reset clears the history, the sample count, the pending result
// and loads the register defaults (coeff 0, center 512, block_length 128).
// ----------------------------------------------------------------------------
module goertzel_tone_magnitude (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [gtm_pkg::SAMPLE_BITS-1:0]        req_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [gtm_pkg::MAG_BITS-1:0]           rsp_magnitude,
   output logic                                   rsp_overflowed,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [gtm_pkg::CSR_BITS-1:0]           csr_index,
   input  logic [gtm_pkg::COEFF_BITS-1:0]         csr_data
);

   localparam int QE_BITS = gtm_pkg::Q_BITS + 2;
   localparam logic [gtm_pkg::ITER_BITS-1:0] ROOT_LAST =
      gtm_pkg::ITER_BITS'(gtm_pkg::ROOT_STEPS - 1);

   gtm_pkg::state_type state_ff, state_in;

   logic [gtm_pkg::COEFF_BITS-1:0]  coeff_ff, coeff_in;
   logic [gtm_pkg::SAMPLE_BITS-1:0] center_ff, center_in;
   logic [gtm_pkg::LEN_BITS-1:0]    length_ff, length_in;

   logic [gtm_pkg::Q_BITS-1:0]      prev_one_ff, prev_one_in;
   logic [gtm_pkg::Q_BITS-1:0]      prev_two_ff, prev_two_in;
   logic [gtm_pkg::LEN_BITS-1:0]    count_ff, count_in;
   logic                            sat_ff, sat_in;

   logic [gtm_pkg::ACC_BITS-1:0]    acc_ff, acc_in;
   logic [gtm_pkg::RAD_BITS-1:0]    tmp_ff, tmp_in;
   logic [gtm_pkg::Q_BITS-1:0]      a1_ff, a1_in;
   logic [gtm_pkg::Q_BITS-1:0]      a2_ff, a2_in;
   logic                            neg_ff, neg_in;
   logic [gtm_pkg::STEP_BITS-1:0]   step_ff, step_in;
   logic                            ovf_ff, ovf_in;

   logic                            big_ff, big_in;
   logic [gtm_pkg::RAD_BITS-1:0]    rad_ff, rad_in;
   logic [gtm_pkg::MAG_BITS:0]      rem_ff, rem_in;
   logic [gtm_pkg::MAG_BITS-1:0]    root_ff, root_in;
   logic [gtm_pkg::ITER_BITS-1:0]   iter_ff, iter_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [gtm_pkg::MAG_BITS-1:0]    mag_ff, mag_in;
   logic                            rsp_ovf_ff, rsp_ovf_in;

   gtm_pkg::step_type               step;
   logic [gtm_pkg::CHUNK_BITS-1:0]  opa;
   logic [gtm_pkg::CHUNK_BITS-1:0]  opb;
   logic [2*gtm_pkg::CHUNK_BITS-1:0] prod;
   logic [gtm_pkg::ACC_BITS-1:0]    term;
   logic [gtm_pkg::ACC_BITS-1:0]    base;
   logic [gtm_pkg::ACC_BITS-1:0]    mac_sum;
   logic                            sub;
   logic [gtm_pkg::COEFF_BITS-1:0]  coeff_mag;

   logic signed [gtm_pkg::SAMPLE_BITS:0] x;
   logic [QE_BITS-1:0]              diff;
   logic [gtm_pkg::ACC_BITS-1-gtm_pkg::FRAC_BITS-gtm_pkg::Q_BITS+1:0] q_hi;
   logic                            q_sat;
   logic [gtm_pkg::Q_BITS-1:0]      q0;
   logic [gtm_pkg::LEN_BITS-1:0]    len_eff;
   logic [gtm_pkg::LEN_BITS-1:0]    count_next;
   logic                            block_end;

   logic [gtm_pkg::MAG_BITS+2:0]    rem_t;
   logic [gtm_pkg::MAG_BITS+3:0]    root_diff;
   logic                            rsp_take;

   function automatic logic [gtm_pkg::CHUNK_BITS-1:0] opnd_pick(
      input gtm_pkg::opnd_type sel,
      input logic [gtm_pkg::COEFF_BITS-1:0] c,
      input logic [gtm_pkg::Q_BITS-1:0] m1,
      input logic [gtm_pkg::Q_BITS-1:0] m2,
      input logic [gtm_pkg::RAD_BITS-1:0] t);
      logic [gtm_pkg::CHUNK_BITS-1:0] r;
      r = '0;
      case (sel)
         gtm_pkg::OPND_COEFF: r = gtm_pkg::CHUNK_BITS'(c);
         gtm_pkg::OPND_A1_LO: r = m1[gtm_pkg::CHUNK_BITS-1:0];
         gtm_pkg::OPND_A1_HI: r = m1[2*gtm_pkg::CHUNK_BITS-1:gtm_pkg::CHUNK_BITS];
         gtm_pkg::OPND_A2_LO: r = m2[gtm_pkg::CHUNK_BITS-1:0];
         gtm_pkg::OPND_A2_HI: r = m2[2*gtm_pkg::CHUNK_BITS-1:gtm_pkg::CHUNK_BITS];
         gtm_pkg::OPND_T_0:   r = t[gtm_pkg::CHUNK_BITS-1:0];
         gtm_pkg::OPND_T_1:   r = t[2*gtm_pkg::CHUNK_BITS-1:gtm_pkg::CHUNK_BITS];
         gtm_pkg::OPND_T_2:   r = gtm_pkg::CHUNK_BITS'(t[gtm_pkg::RAD_BITS-1:
                                                         2*gtm_pkg::CHUNK_BITS]);
         default:             r = '0;
      endcase
      return r;
   endfunction

   // shared multiply-accumulate unit
   always_comb begin
      step      = gtm_pkg::step_ctl(step_ff);
      coeff_mag = coeff_ff[gtm_pkg::COEFF_BITS-1] ? (~coeff_ff + 1'b1) : coeff_ff;
      opa       = opnd_pick(step.a_sel, coeff_mag, a1_ff, a2_ff, tmp_ff);
      opb       = opnd_pick(step.b_sel, coeff_mag, a1_ff, a2_ff, tmp_ff);
      prod      = opa * opb;
      term      = {{(gtm_pkg::ACC_BITS-2*gtm_pkg::CHUNK_BITS){1'b0}}, prod} << step.shift;
      case (step.op)
         gtm_pkg::ACC_SIGNED:     sub = neg_ff;
         gtm_pkg::ACC_SIGNED_INV: sub = ~neg_ff;
         default:                 sub = 1'b0;
      endcase
      base    = step.restart ? '0 : acc_ff;
      mac_sum = sub ? (base - term) : (base + term);
   end

   // sample preload, history saturation, block length, square root step and response take
   always_comb begin
      x    = signed'({1'b0, req_sample}) - signed'({1'b0, center_ff});
      diff = {{(QE_BITS-gtm_pkg::SAMPLE_BITS-1){x[gtm_pkg::SAMPLE_BITS]}}, x}
           - {{2{prev_two_ff[gtm_pkg::Q_BITS-1]}}, prev_two_ff};
      q_hi  = acc_ff[gtm_pkg::ACC_BITS-1:gtm_pkg::FRAC_BITS+gtm_pkg::Q_BITS-1];
      q_sat = (|q_hi) & ~(&q_hi);
      if (q_sat) begin
         q0 = acc_ff[gtm_pkg::ACC_BITS-1] ? gtm_pkg::Q_MIN : gtm_pkg::Q_MAX;
      end else begin
         q0 = acc_ff[gtm_pkg::FRAC_BITS+gtm_pkg::Q_BITS-1:gtm_pkg::FRAC_BITS];
      end
      if (length_ff == '0) begin
         len_eff = gtm_pkg::LEN_BITS'(1);
      end else if (length_ff > gtm_pkg::MAX_BLOCK) begin
         len_eff = gtm_pkg::MAX_BLOCK;
      end else begin
         len_eff = length_ff;
      end
      count_next = count_ff + 1'b1;
      block_end  = count_next >= len_eff;
      rem_t      = {rem_ff, rad_ff[gtm_pkg::RAD_BITS-1:gtm_pkg::RAD_BITS-2]};
      root_diff  = {1'b0, rem_t} - {2'b00, root_ff, 2'b01};
      rsp_take   = rsp_valid_ff & ~rsp_stall;
   end

   always_comb begin
      state_in     = state_ff;
      coeff_in     = coeff_ff;
      center_in    = center_ff;
      length_in    = length_ff;
      prev_one_in  = prev_one_ff;
      prev_two_in  = prev_two_ff;
      count_in     = count_ff;
      sat_in       = sat_ff;
      acc_in       = acc_ff;
      tmp_in       = tmp_ff;
      a1_in        = a1_ff;
      a2_in        = a2_ff;
      neg_in       = neg_ff;
      step_in      = step_ff;
      ovf_in       = ovf_ff;
      big_in       = big_ff;
      rad_in       = rad_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      iter_in      = iter_ff;
      mag_in       = mag_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_valid_in = rsp_take ? 1'b0 : rsp_valid_ff;

      if (csr_valid) begin
         unique case (csr_index)
            gtm_pkg::CSR_COEFF:  coeff_in  = csr_data;
            gtm_pkg::CSR_CENTER: center_in = csr_data[gtm_pkg::SAMPLE_BITS-1:0];
            gtm_pkg::CSR_LENGTH: length_in = csr_data[gtm_pkg::LEN_BITS-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         gtm_pkg::ST_IDLE: begin
            if (req_valid) begin
               acc_in = {{(gtm_pkg::ACC_BITS-QE_BITS-gtm_pkg::FRAC_BITS){diff[QE_BITS-1]}},
                         diff, {gtm_pkg::FRAC_BITS{1'b0}}};
               a1_in   = gtm_pkg::q_abs(prev_one_ff);
               neg_in  = coeff_ff[gtm_pkg::COEFF_BITS-1] ^ prev_one_ff[gtm_pkg::Q_BITS-1];
               step_in = gtm_pkg::STEP_MAC_FIRST;
               state_in = gtm_pkg::ST_MAC;
            end
         end
         gtm_pkg::ST_MAC: begin
            acc_in  = mac_sum;
            step_in = step_ff + 1'b1;
            if (step_ff == gtm_pkg::STEP_MAC_LAST) begin
               state_in = gtm_pkg::ST_UPDATE;
            end
         end
         gtm_pkg::ST_UPDATE: begin
            prev_two_in = prev_one_ff;
            prev_one_in = q0;
            sat_in      = sat_ff | q_sat;
            count_in    = count_next;
            state_in    = block_end ? gtm_pkg::ST_ABS : gtm_pkg::ST_IDLE;
         end
         gtm_pkg::ST_ABS: begin
            a1_in       = gtm_pkg::q_abs(prev_one_ff);
            a2_in       = gtm_pkg::q_abs(prev_two_ff);
            neg_in      = coeff_ff[gtm_pkg::COEFF_BITS-1] ^ prev_one_ff[gtm_pkg::Q_BITS-1]
                        ^ prev_two_ff[gtm_pkg::Q_BITS-1];
            ovf_in      = sat_ff;
            prev_one_in = '0;
            prev_two_in = '0;
            count_in    = '0;
            sat_in      = 1'b0;
            acc_in      = '0;
            step_in     = gtm_pkg::STEP_POW_FIRST;
            state_in    = gtm_pkg::ST_POWER;
         end
         gtm_pkg::ST_POWER: begin
            acc_in  = mac_sum;
            if (step.restart) begin
               tmp_in = acc_ff[gtm_pkg::RAD_BITS-1:0];
            end
            step_in = step_ff + 1'b1;
            if (step_ff == gtm_pkg::STEP_POW_LAST) begin
               state_in = gtm_pkg::ST_PREP;
            end
         end
         gtm_pkg::ST_PREP: begin
            rad_in   = acc_ff[gtm_pkg::RAD_BITS+gtm_pkg::FRAC_BITS-1:gtm_pkg::FRAC_BITS];
            big_in   = |acc_ff[gtm_pkg::ACC_BITS-1:gtm_pkg::RAD_BITS+gtm_pkg::FRAC_BITS];
            rem_in   = '0;
            root_in  = '0;
            iter_in  = '0;
            state_in = gtm_pkg::ST_ROOT;
         end
         gtm_pkg::ST_ROOT: begin
            if (!root_diff[gtm_pkg::MAG_BITS+3]) begin
               rem_in  = root_diff[gtm_pkg::MAG_BITS:0];
               root_in = {root_ff[gtm_pkg::MAG_BITS-2:0], 1'b1};
            end else begin
               rem_in  = rem_t[gtm_pkg::MAG_BITS:0];
               root_in = {root_ff[gtm_pkg::MAG_BITS-2:0], 1'b0};
            end
            rad_in  = rad_ff << 2;
            iter_in = iter_ff + 1'b1;
            if (iter_ff == ROOT_LAST) begin
               state_in = gtm_pkg::ST_DONE;
            end
         end
         gtm_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               mag_in       = big_ff ? '1 : root_ff;
               rsp_ovf_in   = ovf_ff | big_ff;
               rsp_valid_in = 1'b1;
               state_in     = gtm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gtm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gtm_pkg::ST_IDLE;
         coeff_ff     <= gtm_pkg::COEFF_RESET;
         center_ff    <= gtm_pkg::CENTER_RESET;
         length_ff    <= gtm_pkg::LEN_RESET;
         prev_one_ff  <= '0;
         prev_two_ff  <= '0;
         count_ff     <= '0;
         sat_ff       <= 1'b0;
         step_ff      <= '0;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         coeff_ff     <= coeff_in;
         center_ff    <= center_in;
         length_ff    <= length_in;
         prev_one_ff  <= prev_one_in;
         prev_two_ff  <= prev_two_in;
         count_ff     <= count_in;
         sat_ff       <= sat_in;
         step_ff      <= step_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff     <= acc_in;
      tmp_ff     <= tmp_in;
      a1_ff      <= a1_in;
      a2_ff      <= a2_in;
      neg_ff     <= neg_in;
      ovf_ff     <= ovf_in;
      big_ff     <= big_in;
      rad_ff     <= rad_in;
      rem_ff     <= rem_in;
      root_ff    <= root_in;
      mag_ff     <= mag_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   assign req_stall      = (state_ff != gtm_pkg::ST_IDLE);
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_magnitude  = mag_ff;
   assign rsp_overflowed = rsp_ovf_ff;

endmodule
